FILE: src/hjsc_pkg.sv
// Shared types, constants and join tables for the Hangul jamo syllable composer.
// No dependencies; the RTL uses scoped names, the testbench imports it.
package hjsc_pkg;

  localparam int STACK_DEPTH = 6;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CODE_W      = 15;
  localparam int IDX_W       = 5;
  localparam int KIND_W      = 3;
  localparam int PLAIN_W     = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 1;

  // Fill values of the three Johab fields
  localparam logic [IDX_W-1:0]  CHO_FILL   = 5'd1;
  localparam logic [IDX_W-1:0]  JUNG_FILL  = 5'd2;
  localparam logic [IDX_W-1:0]  JONG_FILL  = 5'd1;
  localparam logic [CODE_W-1:0] EMPTY_CODE = {CHO_FILL, JUNG_FILL, JONG_FILL};

  localparam logic OP_KEY   = 1'b0;
  localparam logic OP_ERASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SHUFFLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRICT  = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_UNMAPPED = 3'd0,
    KIND_PLAIN    = 3'd1,
    KIND_INITIAL  = 3'd2,
    KIND_MEDIAL   = 3'd3,
    KIND_FINAL    = 3'd4,
    KIND_BOTH     = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_RAW       = 3'd0,
    ST_EMPTIED   = 3'd1,
    ST_NONHANGUL = 3'd2,
    ST_CORRECT   = 3'd3,
    ST_NEW       = 3'd4,
    ST_CORR_NEW  = 3'd5,
    ST_ERROR     = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    SOP_HOLD,
    SOP_PUSH,
    SOP_POP,
    SOP_CLEAR,
    SOP_LOAD1,
    SOP_LOAD2
  } stack_op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  ini;
    logic [IDX_W-1:0]  med;
    logic [IDX_W-1:0]  fin;
  } jamo_t;

  typedef struct packed {
    jamo_t             jamo;
    logic [CODE_W-1:0] code;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    entry_t           top;
    entry_t           second;
  } stack_view_t;

  typedef struct packed {
    stack_op_t op;
    entry_t    top;
    entry_t    second;
  } stack_cmd_t;

  typedef struct packed {
    logic               op;
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   ini;
    logic [IDX_W-1:0]   med;
    logic [IDX_W-1:0]   fin;
    logic [PLAIN_W-1:0] plain;
  } req_item_t;

  typedef struct packed {
    status_t            status;
    logic [PLAIN_W-1:0] syllable_code;
    logic [CODE_W-1:0]  second_code;
    logic               pending;
  } rsp_item_t;

  // Doubled initials: a consonant typed twice becomes its tense form
  function automatic logic [IDX_W-1:0] join_ini(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] v;
    case (a)
      5'd2, 5'd5, 5'd9, 5'd11, 5'd14: v = a + 5'd1;
      default:                        v = '0;
    endcase
    return v;
  endfunction

  // Compound medials
  function automatic logic [IDX_W-1:0] join_med(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] v;
    v = '0;
    case (a)
      5'd13: begin
        case (b)
          5'd3:    v = 5'd14;
          5'd4:    v = 5'd15;
          5'd29:   v = 5'd18;
          default: v = '0;
        endcase
      end
      5'd20: begin
        case (b)
          5'd7:    v = 5'd21;
          5'd10:   v = 5'd22;
          5'd29:   v = 5'd23;
          default: v = '0;
        endcase
      end
      5'd27: begin
        if (b == 5'd29) v = 5'd28;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

  // Compound finals
  function automatic logic [IDX_W-1:0] join_fin(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
    logic [IDX_W-1:0] v;
    v = '0;
    case (a)
      5'd2: begin
        case (b)
          5'd2:    v = 5'd3;
          5'd21:   v = 5'd4;
          default: v = '0;
        endcase
      end
      5'd5: begin
        case (b)
          5'd24:   v = 5'd6;
          5'd29:   v = 5'd7;
          default: v = '0;
        endcase
      end
      5'd9: begin
        case (b)
          5'd2:    v = 5'd10;
          5'd17:   v = 5'd11;
          5'd19:   v = 5'd12;
          5'd21:   v = 5'd13;
          5'd27:   v = 5'd14;
          5'd28:   v = 5'd15;
          5'd29:   v = 5'd16;
          default: v = '0;
        endcase
      end
      5'd19: begin
        if (b == 5'd21) v = 5'd20;
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: src/hjsc_channels.sv
// Valid/ready channel interfaces for keystroke requests and composer results.
// Depends on hjsc_pkg for field widths.
interface hjsc_req_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [hjsc_pkg::KIND_W-1:0]   jamo_kind;
  logic [hjsc_pkg::IDX_W-1:0]    initial_index;
  logic [hjsc_pkg::IDX_W-1:0]    medial_index;
  logic [hjsc_pkg::IDX_W-1:0]    final_index;
  logic [hjsc_pkg::PLAIN_W-1:0]  plain_code;

  modport source (
    output valid, op, jamo_kind, initial_index, medial_index, final_index, plain_code,
    input  ready
  );
  modport sink (
    input  valid, op, jamo_kind, initial_index, medial_index, final_index, plain_code,
    output ready
  );
endinterface

interface hjsc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [2:0]                    status;
  logic [hjsc_pkg::PLAIN_W-1:0]  syllable_code;
  logic [hjsc_pkg::CODE_W-1:0]   second_code;
  logic                          pending;

  modport source (
    output valid, status, syllable_code, second_code, pending,
    input  ready
  );
  modport sink (
    input  valid, status, syllable_code, second_code, pending,
    output ready
  );
endinterface

FILE: src/hjsc_stack.sv
// Jamo entry stack: a shift register with the top entry at position 0.
// Depends on hjsc_pkg for the entry, command and view types.
module hjsc_stack (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step_en,
  input  hjsc_pkg::stack_cmd_t   cmd,
  output hjsc_pkg::stack_view_t  view
);

  localparam logic [hjsc_pkg::CNT_W-1:0] FULL = hjsc_pkg::CNT_W'(hjsc_pkg::STACK_DEPTH);

  hjsc_pkg::entry_t              entries [hjsc_pkg::STACK_DEPTH];
  logic [hjsc_pkg::CNT_W-1:0]    count;
  logic [hjsc_pkg::CNT_W-1:0]    count_next;

  always_comb begin
    count_next = count;
    case (cmd.op)
      hjsc_pkg::SOP_PUSH:  if (count < FULL) count_next = count + 1'b1;
      hjsc_pkg::SOP_POP:   if (count != '0) count_next = count - 1'b1;
      hjsc_pkg::SOP_CLEAR: count_next = '0;
      hjsc_pkg::SOP_LOAD1: count_next = hjsc_pkg::CNT_W'(1);
      hjsc_pkg::SOP_LOAD2: count_next = hjsc_pkg::CNT_W'(2);
      default:             count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (step_en) begin
      count <= count_next;
    end
  end

  // A push onto a full stack overwrites the top without shifting
  always_ff @(posedge clk) begin
    if (step_en) begin
      case (cmd.op)
        hjsc_pkg::SOP_PUSH: begin
          if (count < FULL) begin
            for (int i = 1; i < hjsc_pkg::STACK_DEPTH; i++) entries[i] <= entries[i-1];
          end
          entries[0] <= cmd.top;
        end
        hjsc_pkg::SOP_POP: begin
          for (int i = 0; i < hjsc_pkg::STACK_DEPTH - 1; i++) entries[i] <= entries[i+1];
        end
        hjsc_pkg::SOP_LOAD1: begin
          entries[0] <= cmd.top;
        end
        hjsc_pkg::SOP_LOAD2: begin
          entries[0] <= cmd.top;
          entries[1] <= cmd.second;
        end
        default: ;
      endcase
    end
  end

  assign view.count  = count;
  assign view.top    = entries[0];
  assign view.second = entries[1];

endmodule

FILE: src/hjsc_step.sv
// Composition step: decides the stack update and the result for one keystroke.
// Depends on hjsc_pkg for types, codes and join tables.
module hjsc_step (
  input  hjsc_pkg::req_item_t    item,
  input  hjsc_pkg::stack_view_t  view,
  input  logic                   shuffle_mode,
  input  logic                   strict_errors,
  output hjsc_pkg::stack_cmd_t   cmd,
  output hjsc_pkg::rsp_item_t    rsp
);

  logic [hjsc_pkg::CODE_W-1:0] cur;
  logic                        has_ini;
  logic                        has_med;
  logic                        has_fin;
  logic                        one_entry;
  logic                        multi;
  hjsc_pkg::jamo_t             jamo;
  logic [hjsc_pkg::IDX_W-1:0]  ji;
  logic [hjsc_pkg::IDX_W-1:0]  jm;
  logic [hjsc_pkg::IDX_W-1:0]  jf;
  logic [hjsc_pkg::CODE_W-1:0] new_ini;
  logic [hjsc_pkg::CODE_W-1:0] new_med;
  logic [hjsc_pkg::CODE_W-1:0] split_ini;

  assign cur       = (view.count == '0) ? hjsc_pkg::EMPTY_CODE : view.top.code;
  assign has_ini   = cur[14:10] != hjsc_pkg::CHO_FILL;
  assign has_med   = cur[9:5]   != hjsc_pkg::JUNG_FILL;
  assign has_fin   = cur[4:0]   != hjsc_pkg::JONG_FILL;
  assign one_entry = view.count == hjsc_pkg::CNT_W'(1);
  assign multi     = view.count > hjsc_pkg::CNT_W'(1);
  assign jamo      = '{kind: item.kind, ini: item.ini, med: item.med, fin: item.fin};

  // Doubled initial only right after a lone initial of the same consonant
  assign ji = (one_entry && view.top.jamo.ini == item.ini) ?
              hjsc_pkg::join_ini(item.ini) : '0;
  assign jm = (view.count != '0 &&
               !(multi && view.second.jamo.kind == hjsc_pkg::KIND_MEDIAL)) ?
              hjsc_pkg::join_med(view.top.jamo.med, item.med) : '0;
  assign jf = (view.count != '0 &&
               !(view.count > hjsc_pkg::CNT_W'(2) &&
                 view.second.jamo.kind != hjsc_pkg::KIND_MEDIAL)) ?
              hjsc_pkg::join_fin(view.top.jamo.fin, item.fin) : '0;

  // Fresh syllables holding a single initial or a single medial
  assign new_ini   = {item.ini, hjsc_pkg::JUNG_FILL, hjsc_pkg::JONG_FILL};
  assign new_med   = {hjsc_pkg::CHO_FILL, item.med, hjsc_pkg::JONG_FILL};
  assign split_ini = {view.top.jamo.ini, hjsc_pkg::JUNG_FILL, hjsc_pkg::JONG_FILL};

  always_comb begin
    cmd.op          = hjsc_pkg::SOP_HOLD;
    cmd.top.jamo    = jamo;
    cmd.top.code    = cur;
    cmd.second      = view.top;
    rsp.status      = hjsc_pkg::ST_ERROR;
    rsp.syllable_code = '0;
    rsp.second_code = '0;
    rsp.pending     = 1'b0;

    if (item.op == hjsc_pkg::OP_ERASE) begin
      if (view.count == '0) begin
        rsp.status = hjsc_pkg::ST_RAW;
      end else if (one_entry) begin
        cmd.op     = hjsc_pkg::SOP_CLEAR;
        rsp.status = hjsc_pkg::ST_EMPTIED;
      end else begin
        cmd.op            = hjsc_pkg::SOP_POP;
        rsp.status        = hjsc_pkg::ST_CORRECT;
        rsp.syllable_code = {1'b0, view.second.code};
      end
    end else begin
      case (hjsc_pkg::kind_t'(item.kind))
        hjsc_pkg::KIND_UNMAPPED: begin
          cmd.op     = hjsc_pkg::SOP_CLEAR;
          rsp.status = hjsc_pkg::ST_RAW;
        end
        hjsc_pkg::KIND_PLAIN: begin
          cmd.op            = hjsc_pkg::SOP_CLEAR;
          rsp.status        = hjsc_pkg::ST_NONHANGUL;
          rsp.syllable_code = item.plain;
        end
        hjsc_pkg::KIND_INITIAL: begin
          if (has_fin || (has_ini && has_med)) begin
            cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_ini;
            rsp.status = hjsc_pkg::ST_NEW;
          end else if (!has_ini) begin
            if (view.count != '0 && shuffle_mode) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {item.ini, cur[9:0]};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end else begin
              cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_ini;
              rsp.status = hjsc_pkg::ST_NEW;
            end
          end else if (ji != '0) begin
            cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {ji, cur[9:0]};
            rsp.status = hjsc_pkg::ST_CORRECT;
          end else if (!strict_errors) begin
            cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_ini;
            rsp.status = hjsc_pkg::ST_NEW;
          end
        end
        hjsc_pkg::KIND_MEDIAL: begin
          if (has_fin) begin
            if (view.top.jamo.kind == hjsc_pkg::KIND_BOTH) begin
              // Move the final over: it starts the new syllable as its initial
              cmd.op          = hjsc_pkg::SOP_LOAD2;
              cmd.second.code = split_ini;
              cmd.top.code    = {view.top.jamo.ini, item.med, hjsc_pkg::JONG_FILL};
              rsp.status      = hjsc_pkg::ST_CORR_NEW;
              rsp.syllable_code = {1'b0, multi ? view.second.code : hjsc_pkg::EMPTY_CODE};
              rsp.second_code = {view.top.jamo.ini, item.med, hjsc_pkg::JONG_FILL};
            end else begin
              cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_med;
              rsp.status = hjsc_pkg::ST_NEW;
            end
          end else if (has_med) begin
            if (jm != '0) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {cur[14:10], jm, cur[4:0]};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end else if (shuffle_mode || !strict_errors) begin
              cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_med;
              rsp.status = hjsc_pkg::ST_NEW;
            end
          end else begin
            cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {cur[14:10], item.med, cur[4:0]};
            rsp.status = has_ini ? hjsc_pkg::ST_CORRECT : hjsc_pkg::ST_NEW;
          end
        end
        hjsc_pkg::KIND_FINAL: begin
          if (has_ini && has_med) begin
            if (!has_fin) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {cur[14:5], item.fin};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end else if (jf != '0) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {cur[14:5], jf};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end
          end
        end
        hjsc_pkg::KIND_BOTH: begin
          if (has_fin) begin
            if (jf != '0) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {cur[14:5], jf};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end else begin
              cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_ini;
              rsp.status = hjsc_pkg::ST_NEW;
            end
          end else if (has_med) begin
            // Shuffle with a lone vowel: the consonant becomes its initial
            cmd.op = hjsc_pkg::SOP_PUSH;
            cmd.top.code = (shuffle_mode && one_entry) ? {item.ini, cur[9:0]} :
                                                         {cur[14:5], item.fin};
            rsp.status = hjsc_pkg::ST_CORRECT;
          end else if (has_ini) begin
            if (ji != '0) begin
              cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {ji, cur[9:0]};
              rsp.status = hjsc_pkg::ST_CORRECT;
            end else if (!strict_errors) begin
              cmd.op = hjsc_pkg::SOP_LOAD1; cmd.top.code = new_ini;
              rsp.status = hjsc_pkg::ST_NEW;
            end
          end else begin
            cmd.op = hjsc_pkg::SOP_PUSH; cmd.top.code = {item.ini, cur[9:0]};
            rsp.status = hjsc_pkg::ST_NEW;
          end
        end
        default: ;
      endcase
    end

    if (cmd.op == hjsc_pkg::SOP_PUSH || cmd.op == hjsc_pkg::SOP_LOAD1) begin
      rsp.syllable_code = {1'b0, cmd.top.code};
    end

    case (cmd.op)
      hjsc_pkg::SOP_HOLD:  rsp.pending = view.count != '0;
      hjsc_pkg::SOP_POP:   rsp.pending = multi;
      hjsc_pkg::SOP_CLEAR: rsp.pending = 1'b0;
      default:             rsp.pending = 1'b1;
    endcase
  end

endmodule

FILE: src/hangul_jamo_syllable_composer_unit.sv
// Top level of the Hangul jamo syllable composer (two-set layout, Johab codes).
// Depends on hjsc_pkg, hjsc_channels (interfaces), hjsc_stack and hjsc_step.
//
// Usage:
//   req  - keystroke requests: op (key or erase), jamo_kind, the three Johab
//          indices and plain_code for non-Hangul keys.
//   rsp  - one result per request: status, syllable_code, second_code and
//          pending (a syllable is still being composed).
//   cfg  - cfg_we / cfg_index / cfg_data write shuffle_mode (index 0) and
//          strict_errors (index 1); write them only while no request is in
//          flight.
// Throughput: one request per cycle while rsp is ready. The request
//   register and the result register form a two-stage pipe, and a result
//   shows on rsp once its request has moved through both. The jamo stack is
//   updated as a request moves into the result register, so the next
//   request already sees it.
// Stall: while rsp is held off the result waits in its register; one more
//   request is taken into the request register, then req.ready drops.
// Reset: rst (synchronous) empties the stack, drops both pipe stages and sets
//   shuffle_mode to 0 and strict_errors to 1.
module hangul_jamo_syllable_composer_unit (
  input  logic                             clk,
  input  logic                             rst,
  hjsc_req_if.sink                         req,
  hjsc_rsp_if.source                       rsp,
  input  logic                             cfg_we,
  input  logic [hjsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [hjsc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic                   shuffle_mode;
  logic                   strict_errors;

  logic                   req_valid;
  hjsc_pkg::req_item_t    req_item;
  logic                   rsp_valid;
  hjsc_pkg::rsp_item_t    rsp_item;

  logic                   advance;
  logic                   req_take;
  logic                   step_en;

  hjsc_pkg::stack_view_t  view;
  hjsc_pkg::stack_cmd_t   cmd;
  hjsc_pkg::rsp_item_t    step_rsp;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      shuffle_mode  <= 1'b0;
      strict_errors <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        hjsc_pkg::CFG_SHUFFLE: shuffle_mode  <= cfg_data[0];
        hjsc_pkg::CFG_STRICT:  strict_errors <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipe control: advance when the result slot is free or being drained
  assign advance   = !rsp_valid || rsp.ready;
  assign req.ready = !req_valid || advance;
  assign req_take  = req.valid && req.ready;
  assign step_en   = req_valid && advance;

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_take) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      req_item <= '{op: req.op, kind: req.jamo_kind, ini: req.initial_index,
                    med: req.medial_index, fin: req.final_index, plain: req.plain_code};
    end
  end

  hjsc_stack u_stack (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .cmd     (cmd),
    .view    (view)
  );

  hjsc_step u_step (
    .item          (req_item),
    .view          (view),
    .shuffle_mode  (shuffle_mode),
    .strict_errors (strict_errors),
    .cmd           (cmd),
    .rsp           (step_rsp)
  );

  // Result register: load together with the stack update
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      rsp_item <= step_rsp;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_item.status;
  assign rsp.syllable_code = rsp_item.syllable_code;
  assign rsp.second_code   = rsp_item.second_code;
  assign rsp.pending       = rsp_item.pending;

  // Assertions

  // A waiting result's pending flag matches the stack it left behind
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_item.pending == (view.count != '0)))
    else $error("pending flag disagrees with stack depth");

  assert property (@(posedge clk) disable iff (rst)
    view.count <= hjsc_pkg::CNT_W'(hjsc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  // A request with a free result slot must move into it in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (req_valid && !rsp_valid) |=> rsp_valid)
    else $error("request stuck with result slot free");

  assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_item.status != hjsc_pkg::ST_CORR_NEW) |-> (rsp_item.second_code == '0))
    else $error("second code set without a syllable split");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for hangul_jamo_syllable_composer_unit: keystroke requests in,
// one syllable result per request out, each checked against a cycle-free composer model.
// Depends on hjsc_pkg, the hjsc_req_if / hjsc_rsp_if channels and the composer RTL.
module tb_top;
  import hjsc_pkg::*;

  // Kind code outside the defined set, answered with an error
  localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd6;
  localparam int unsigned PHASE_KEYS = 360;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hjsc_req_if key_ch ();
  hjsc_rsp_if syl_ch ();

  hangul_jamo_syllable_composer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req       (key_ch),
    .rsp       (syl_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Keystrokes waiting to be sent, and syllable results still owed by the block
  req_item_t   keystroke_q[$];
  rsp_item_t   awaited_results[$];
  int unsigned keys_queued;
  int unsigned mismatches;

  // Composer model state: the settings and the jamo stack with the code after each jamo
  logic              shuffle_on;
  logic              strict_on;
  int unsigned       depth_used;
  jamo_t             typed [STACK_DEPTH];
  logic [CODE_W-1:0] built [STACK_DEPTH];

  // Driver and monitor state
  req_item_t   on_wire;
  int unsigned send_gap;
  bit          send_burst;
  rsp_item_t   want;
  int unsigned hold_off;
  bit          take_burst;

  //--------------------------------------------------------------------------
  // Composer model
  //--------------------------------------------------------------------------
  function automatic logic [CODE_W-1:0] top_syllable();
    return (depth_used != 0) ? built[depth_used-1] : EMPTY_CODE;
  endfunction

  function automatic bit has_lead();
    logic [CODE_W-1:0] c;
    c = top_syllable();
    return c[14:10] != CHO_FILL;
  endfunction

  function automatic bit has_vowel();
    logic [CODE_W-1:0] c;
    c = top_syllable();
    return c[9:5] != JUNG_FILL;
  endfunction

  function automatic bit has_tail();
    logic [CODE_W-1:0] c;
    c = top_syllable();
    return c[4:0] != JONG_FILL;
  endfunction

  // A full stack keeps its depth: the new entry replaces the top one
  function automatic void stack_push(input jamo_t j, input logic [CODE_W-1:0] code);
    if (depth_used < STACK_DEPTH) depth_used++;
    typed[depth_used-1] = j;
    built[depth_used-1] = code;
  endfunction

  // Replace one field of the top syllable; a zero value takes the jamo's own index
  function automatic void push_lead(input jamo_t j, input logic [IDX_W-1:0] v);
    logic [CODE_W-1:0] c;
    c = top_syllable();
    if (v == 0) v = j.ini;
    stack_push(j, {v, c[9:5], c[4:0]});
  endfunction

  function automatic void push_vowel(input jamo_t j, input logic [IDX_W-1:0] v);
    logic [CODE_W-1:0] c;
    c = top_syllable();
    if (v == 0) v = j.med;
    stack_push(j, {c[14:10], v, c[4:0]});
  endfunction

  function automatic void push_tail(input jamo_t j, input logic [IDX_W-1:0] v);
    logic [CODE_W-1:0] c;
    c = top_syllable();
    if (v == 0) v = j.fin;
    stack_push(j, {c[14:10], c[9:5], v});
  endfunction

  // Tense initial: only the very first jamo typed twice doubles
  function automatic logic [IDX_W-1:0] tense_initial(input jamo_t j);
    logic [IDX_W-1:0] a;
    if (depth_used != 1) return '0;
    a = typed[0].ini;
    if (a != j.ini) return '0;
    case (a)
      5'd2, 5'd5, 5'd9, 5'd11, 5'd14: return a + 5'd1;
      default:                        return '0;
    endcase
  endfunction

  // Compound vowel: not after a vowel that was already compound
  function automatic logic [IDX_W-1:0] compound_vowel(input jamo_t j);
    logic [IDX_W-1:0] a;
    if (depth_used == 0) return '0;
    if (depth_used >= 2 && typed[depth_used-2].kind == KIND_MEDIAL) return '0;
    a = typed[depth_used-1].med;
    case (a)
      5'd13: return (j.med == 5'd3) ? 5'd14 : (j.med == 5'd4) ? 5'd15 :
                    (j.med == 5'd29) ? 5'd18 : 5'd0;
      5'd20: return (j.med == 5'd7) ? 5'd21 : (j.med == 5'd10) ? 5'd22 :
                    (j.med == 5'd29) ? 5'd23 : 5'd0;
      5'd27: return (j.med == 5'd29) ? 5'd28 : 5'd0;
      default: return '0;
    endcase
  endfunction

  // Compound final: the single final must follow a vowel directly
  function automatic logic [IDX_W-1:0] compound_final(input jamo_t j);
    logic [IDX_W-1:0] a;
    if (depth_used == 0) return '0;
    if (depth_used >= 3 && typed[depth_used-2].kind != KIND_MEDIAL) return '0;
    a = typed[depth_used-1].fin;
    case (a)
      5'd2:  return (j.fin == 5'd2) ? 5'd3 : (j.fin == 5'd21) ? 5'd4 : 5'd0;
      5'd5:  return (j.fin == 5'd24) ? 5'd6 : (j.fin == 5'd29) ? 5'd7 : 5'd0;
      5'd9: begin
        case (j.fin)
          5'd2:    return 5'd10;
          5'd17:   return 5'd11;
          5'd19:   return 5'd12;
          5'd21:   return 5'd13;
          5'd27:   return 5'd14;
          5'd28:   return 5'd15;
          5'd29:   return 5'd16;
          default: return '0;
        endcase
      end
      5'd19: return (j.fin == 5'd21) ? 5'd20 : 5'd0;
      default: return '0;
    endcase
  endfunction

  // Advance the model by one accepted request and return the result it owes
  function automatic rsp_item_t compose_keystroke(input req_item_t r);
    jamo_t            j;
    jamo_t            last;
    status_t          st;
    logic [15:0]      s1;
    logic [CODE_W-1:0] s2;
    logic [IDX_W-1:0] v;
    rsp_item_t        res;
    j.kind = r.kind;
    j.ini  = r.ini;
    j.med  = r.med;
    j.fin  = r.fin;
    st = ST_ERROR;
    s1 = '0;
    s2 = '0;
    if (r.op == OP_ERASE) begin
      if (depth_used == 0) st = ST_RAW;
      else if (depth_used == 1) begin
        depth_used = 0;
        st = ST_EMPTIED;
      end else begin
        depth_used--;
        st = ST_CORRECT;
      end
    end else if (r.kind == KIND_UNMAPPED) begin
      depth_used = 0;
      st = ST_RAW;
    end else if (r.kind == KIND_PLAIN) begin
      depth_used = 0;
      st = ST_NONHANGUL;
      s1 = r.plain;
    end else if (r.kind == KIND_INITIAL) begin
      v = tense_initial(j);
      if (has_tail() || (has_lead() && has_vowel())) begin
        depth_used = 0;
        push_lead(j, '0);
        st = ST_NEW;
      end else if (!has_lead()) begin
        push_lead(j, '0);
        if (depth_used > 1 && shuffle_on) st = ST_CORRECT;
        else begin
          depth_used = 0;
          push_lead(j, '0);
          st = ST_NEW;
        end
      end else if (v != 0) begin
        push_lead(j, v);
        st = ST_CORRECT;
      end else if (!strict_on) begin
        depth_used = 0;
        push_lead(j, '0);
        st = ST_NEW;
      end
    end else if (r.kind == KIND_MEDIAL) begin
      if (has_tail()) begin
        last = typed[depth_used-1];
        if (last.kind == KIND_BOTH) begin
          // the final moves over to start the next syllable
          depth_used--;
          s1 = {1'b0, top_syllable()};
          depth_used = 0;
          push_lead(last, '0);
          push_vowel(j, '0);
          s2 = top_syllable();
          st = ST_CORR_NEW;
        end else begin
          depth_used = 0;
          push_vowel(j, '0);
          st = ST_NEW;
        end
      end else if (has_vowel()) begin
        v = compound_vowel(j);
        if (v != 0) begin
          push_vowel(j, v);
          st = ST_CORRECT;
        end else if (shuffle_on || !strict_on) begin
          depth_used = 0;
          push_vowel(j, '0);
          st = ST_NEW;
        end
      end else begin
        st = has_lead() ? ST_CORRECT : ST_NEW;
        push_vowel(j, '0);
      end
    end else if (r.kind == KIND_FINAL) begin
      if (has_lead() && has_vowel()) begin
        if (!has_tail()) begin
          push_tail(j, '0);
          st = ST_CORRECT;
        end else begin
          v = compound_final(j);
          if (v != 0) begin
            push_tail(j, v);
            st = ST_CORRECT;
          end
        end
      end
    end else if (r.kind == KIND_BOTH) begin
      if (has_tail()) begin
        v = compound_final(j);
        if (v != 0) begin
          push_tail(j, v);
          st = ST_CORRECT;
        end else begin
          depth_used = 0;
          push_lead(j, '0);
          st = ST_NEW;
        end
      end else if (has_vowel()) begin
        push_tail(j, '0);
        if (!shuffle_on || depth_used > 2) st = ST_CORRECT;
        else begin
          // vowel typed first: the consonant becomes its initial instead
          depth_used--;
          if (depth_used == 1) begin
            push_lead(j, '0);
            st = ST_CORRECT;
          end
        end
        if (st != ST_CORRECT) begin
          depth_used = 0;
          push_lead(j, '0);
          st = ST_NEW;
        end
      end else if (has_lead()) begin
        v = tense_initial(j);
        if (v != 0) begin
          push_lead(j, v);
          st = ST_CORRECT;
        end else if (!strict_on) begin
          depth_used = 0;
          push_lead(j, '0);
          st = ST_NEW;
        end
      end else begin
        push_lead(j, '0);
        st = ST_NEW;
      end
    end
    if (st == ST_CORRECT || st == ST_NEW) s1 = {1'b0, top_syllable()};
    res.status        = st;
    res.syllable_code = s1;
    res.second_code   = s2;
    res.pending       = (depth_used != 0);
    return res;
  endfunction

  //--------------------------------------------------------------------------
  // Stimulus helpers
  //--------------------------------------------------------------------------
  task automatic queue_key(input logic op, input int unsigned kind, input int unsigned ini,
                           input int unsigned med, input int unsigned fin,
                           input int unsigned plain);
    req_item_t r;
    r.op    = op;
    r.kind  = kind[KIND_W-1:0];
    r.ini   = ini[IDX_W-1:0];
    r.med   = med[IDX_W-1:0];
    r.fin   = fin[IDX_W-1:0];
    r.plain = plain[PLAIN_W-1:0];
    keystroke_q.push_back(r);
    keys_queued++;
  endtask

  // Favor the consonants that have a tense form
  function automatic int unsigned pick_consonant();
    case ($urandom_range(0, 9))
      0:       return 2;
      1:       return 5;
      2:       return 9;
      3:       return 11;
      4:       return 14;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // Second half of a compound vowel or final, 0 when the first has none
  function automatic int unsigned compound_mate(input bit is_vowel, input int unsigned a);
    if (is_vowel) begin
      case (a)
        13: return ($urandom_range(0, 2) == 0) ? 3 : ($urandom_range(0, 1) ? 4 : 29);
        20: return ($urandom_range(0, 2) == 0) ? 7 : ($urandom_range(0, 1) ? 10 : 29);
        27: return 29;
        default: return 0;
      endcase
    end
    case (a)
      2:  return $urandom_range(0, 1) ? 2 : 21;
      5:  return $urandom_range(0, 1) ? 24 : 29;
      9: begin
        case ($urandom_range(0, 6))
          0:       return 2;
          1:       return 17;
          2:       return 19;
          3:       return 21;
          4:       return 27;
          5:       return 28;
          default: return 29;
        endcase
      end
      19: return 21;
      default: return 0;
    endcase
  endfunction

  // One syllable typed the way a user would, with random content; now and then
  // the vowel comes first, or the burst is a single key of random noise
  task automatic queue_burst();
    int unsigned lead;
    int unsigned lead_kind;
    int unsigned strokes;
    int unsigned vowel;
    int unsigned tail;
    int unsigned mate;
    bit          vowel_first;
    if ($urandom_range(0, 4) == 0) begin
      queue_key($urandom_range(0, 7) == 0, $urandom_range(0, 7), $urandom_range(0, 20),
                $urandom_range(0, 29), $urandom_range(0, 29), $urandom_range(0, 65535));
      return;
    end
    vowel_first = ($urandom_range(0, 6) == 0);
    lead        = pick_consonant();
    lead_kind   = ($urandom_range(0, 3) == 0) ? KIND_INITIAL : KIND_BOTH;
    strokes     = ($urandom_range(0, 3) == 0) ? 2 : 1;
    case ($urandom_range(0, 3))
      0:       vowel = 13;
      1:       vowel = 20;
      2:       vowel = 27;
      default: vowel = $urandom_range(3, 29);
    endcase
    if (!vowel_first)
      repeat (strokes) queue_key(OP_KEY, lead_kind, lead, 0, lead, $urandom_range(0, 65535));
    queue_key(OP_KEY, KIND_MEDIAL, 0, vowel, 0, $urandom_range(0, 65535));
    mate = compound_mate(1'b1, vowel);
    if (mate != 0 && $urandom_range(0, 1))
      queue_key(OP_KEY, KIND_MEDIAL, 0, mate, 0, $urandom_range(0, 65535));
    if (vowel_first)
      repeat (strokes) queue_key(OP_KEY, lead_kind, lead, 0, lead, $urandom_range(0, 65535));
    if ($urandom_range(0, 9) < 6) begin
      case ($urandom_range(0, 4))
        0:       tail = 2;
        1:       tail = 5;
        2:       tail = 9;
        3:       tail = 19;
        default: tail = $urandom_range(1, 29);
      endcase
      queue_key(OP_KEY, ($urandom_range(0, 9) < 7) ? KIND_BOTH : KIND_FINAL,
                pick_consonant(), 0, tail, $urandom_range(0, 65535));
      mate = compound_mate(1'b0, tail);
      if (mate != 0 && $urandom_range(0, 9) < 4)
        queue_key(OP_KEY, ($urandom_range(0, 9) < 7) ? KIND_BOTH : KIND_FINAL,
                  pick_consonant(), 0, mate, $urandom_range(0, 65535));
    end
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 2))
        queue_key(OP_ERASE, $urandom_range(0, 7), 0, 0, 0, $urandom_range(0, 65535));
  endtask

  // Hold until every queued request is sent and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (keystroke_q.size() != 0 || key_ch.valid === 1'b1 || awaited_results.size() != 0);
    repeat (2) @(negedge clk);
  endtask

  // Single-cycle register write, mirrored into the model once it lands
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SHUFFLE) shuffle_on = val;
    else strict_on = val;
  endtask

  task automatic report(input string field, input int unsigned exp_v, input int unsigned got_v);
    $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, exp_v, got_v);
    mismatches++;
  endtask

  //--------------------------------------------------------------------------
  // Clock and time limit
  //--------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Time limit with a wide margin over the whole test sequence
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  //--------------------------------------------------------------------------
  // Request driver: pop the next keystroke once the last request is taken,
  // after a random idle gap (none during a burst stretch). The model
  // advances at the edge where a request is accepted.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      key_ch.valid <= 1'b0;
      depth_used = 0;
      send_gap   = 0;
    end else begin
      if (key_ch.valid && key_ch.ready)
        awaited_results.push_back(compose_keystroke(on_wire));
      if (!key_ch.valid || key_ch.ready) begin
        if (send_gap > 0 || keystroke_q.size() == 0) begin
          if (send_gap > 0) send_gap--;
          key_ch.valid <= 1'b0;
        end else begin
          on_wire = keystroke_q.pop_front();
          key_ch.valid         <= 1'b1;
          key_ch.op            <= on_wire.op;
          key_ch.jamo_kind     <= on_wire.kind;
          key_ch.initial_index <= on_wire.ini;
          key_ch.medial_index  <= on_wire.med;
          key_ch.final_index   <= on_wire.fin;
          key_ch.plain_code    <= on_wire.plain;
          if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
          send_gap = send_burst ? 0 : $urandom_range(0, 3);
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // Result monitor: check each accepted result against the oldest expectation,
  // then hold ready low for a random stretch before taking the next one.
  //--------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      syl_ch.ready <= 1'b0;
      hold_off = 0;
    end else begin
      if (syl_ch.valid && syl_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d code 0x%0h", $time, syl_ch.status,
                   syl_ch.syllable_code);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (syl_ch.status !== want.status) report("status", want.status, syl_ch.status);
          if (syl_ch.syllable_code !== want.syllable_code)
            report("syllable_code", want.syllable_code, syl_ch.syllable_code);
          if (syl_ch.second_code !== want.second_code)
            report("second_code", want.second_code, syl_ch.second_code);
          if (syl_ch.pending !== want.pending) report("pending", want.pending, syl_ch.pending);
        end
        if ($urandom_range(0, 49) == 0) take_burst = !take_burst;
        hold_off = take_burst ? 0 : $urandom_range(0, 3);
      end
      if (hold_off > 0) begin
        hold_off--;
        syl_ch.ready <= 1'b0;
      end else begin
        syl_ch.ready <= 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Test sequence
  //--------------------------------------------------------------------------
  initial begin
    int unsigned start_count;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_SHUFFLE;
    cfg_data             = '0;
    key_ch.valid         = 1'b0;
    key_ch.op            = OP_KEY;
    key_ch.jamo_kind     = KIND_UNMAPPED;
    key_ch.initial_index = '0;
    key_ch.medial_index  = '0;
    key_ch.final_index   = '0;
    key_ch.plain_code    = '0;
    syl_ch.ready         = 1'b0;
    shuffle_on           = 1'b0;
    strict_on            = 1'b1;
    depth_used           = 0;
    keys_queued          = 0;
    mismatches           = 0;
    send_burst           = 1'b0;
    take_burst           = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings: erase on an empty stack, an
    // unknown kind, a non-Hangul key, a stray final, then a syllable with a
    // tense initial, compound vowel and compound final that splits on a vowel
    @(negedge clk);
    queue_key(OP_ERASE, KIND_UNMAPPED, 0, 0, 0, 0);
    queue_key(OP_KEY, KIND_RESERVED, 20, 29, 29, 16'hffff);
    queue_key(OP_KEY, KIND_PLAIN, 0, 0, 0, 16'hffff);
    queue_key(OP_KEY, KIND_FINAL, 0, 0, 29, 0);
    queue_key(OP_KEY, KIND_BOTH, 2, 0, 2, 0);
    queue_key(OP_KEY, KIND_BOTH, 2, 0, 2, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 13, 0, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 3, 0, 0);
    queue_key(OP_KEY, KIND_BOTH, 6, 0, 9, 0);
    queue_key(OP_KEY, KIND_BOTH, 2, 0, 2, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 20, 0, 0);
    // strict mode: an initial that cannot double is an error
    queue_key(OP_KEY, KIND_INITIAL, 20, 0, 0, 0);
    queue_key(OP_KEY, KIND_INITIAL, 5, 0, 0, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 29, 0, 0);
    // unmapped key drops the syllable in progress
    queue_key(OP_KEY, KIND_UNMAPPED, 0, 0, 0, 0);
    // fill vowels never combine or fill a slot, so seven of them overflow the stack
    repeat (7) queue_key(OP_KEY, KIND_MEDIAL, 0, JUNG_FILL, 0, 0);
    queue_key(OP_ERASE, KIND_UNMAPPED, 0, 0, 0, 0);
    wait_idle();

    // Shuffle mode: a vowel that does not combine starts over despite strict mode
    write_reg(CFG_SHUFFLE, 1'b1);
    @(negedge clk);
    queue_key(OP_KEY, KIND_BOTH, 2, 0, 2, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 13, 0, 0);
    queue_key(OP_KEY, KIND_MEDIAL, 0, 7, 0, 0);
    wait_idle();

    // Random phases, one per pair of settings; the sender drains fully before
    // each register write
    for (int phase = 0; phase < 4; phase++) begin
      write_reg(CFG_SHUFFLE, (phase == 0 || phase == 2));
      write_reg(CFG_STRICT, (phase == 0 || phase == 3));
      @(negedge clk);
      start_count = keys_queued;
      while (keys_queued - start_count < PHASE_KEYS) queue_burst();
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
